[rtl/uer_pkg.sv]
`timescale 1ns / 1ps
package uer_pkg;

	localparam int COUNT_W     = 15;
	localparam int DIST_W      = 14;
	localparam int TRIG_W      = 8;
	localparam int TMO_W       = 15;
	localparam int DREG_W      = 13;
	localparam int LVL_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 15;

	localparam int SPEED_W     = 11;
	localparam int SPEED_SHIFT = 12;
	localparam logic [SPEED_W-1:0] SPEED_Q12 = 11'd1124;

	localparam int PROD_W  = COUNT_W + SPEED_W;
	localparam int SDIST_W = PROD_W - SPEED_SHIFT;
	localparam int SAT_W   = (SDIST_W > DIST_W) ? SDIST_W : DIST_W;
	localparam int RCMP_W  = (DIST_W > DREG_W) ? DIST_W : DREG_W;
	localparam int TCMP_W  = (COUNT_W > TMO_W) ? COUNT_W : TMO_W;

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [LVL_W-1:0] LVL_SCALE = 10'd1000;
	localparam int NUM_W  = DREG_W + LVL_W;
	localparam int STEP_W = $clog2(LVL_W);

	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIGGER,
		REG_TIMEOUT,
		REG_MIN_DIST,
		REG_MAX_DIST,
		REG_TANK
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_RISE_TMO,
		ST_HIGH_TMO,
		ST_RANGE
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TRIG,
		PH_RISE,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [TRIG_W-1:0] trigger_ticks;
		logic [TMO_W-1:0]  timeout_ticks;
		logic [DREG_W-1:0] min_distance_x16;
		logic [DREG_W-1:0] max_distance_x16;
		logic [DREG_W-1:0] tank_height_x16;
	} cfg_t;

	typedef struct packed {
		logic              trig;
		logic              done;
		status_t           status;
		logic [DIST_W-1:0] dist_x16;
	} entry_t;

endpackage

[rtl/ultrasonic_echo_ranger.sv]
`timescale 1ns / 1ps
// Ultrasonic echo ranger.
// Input channel (in_valid / in_stall): one beat per microsecond tick with
// start_req and the sampled echo_level. Output channel (out_valid /
// out_stall): exactly one beat per input beat with the trigger pin level,
// done_res, status, distance_x16 and level_permille of the last finished
// measurement.
// The tick sequencer takes a beat and queues its result in the same cycle;
// a two-entry queue feeds the level unit, a restoring divider that yields
// one quotient bit per cycle. Each beat passes through the level unit in
// order (pop, setup, 10 divide steps, output load); the unit works on one
// beat at a time while the queue holds further beats.
// When the receiver stalls, the output register holds, the queue fills and
// in_stall rises; no beat is dropped.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always
// ready. The user must write it only while no beats are in flight; the
// block does not enforce this. Reset clears the sequencer to idle, the last
// result to status ok and distance 0, and loads the register defaults.
module ultrasonic_echo_ranger
	import uer_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_req,
	input  logic                  echo_level,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  trigger_out,
	output logic                  done_res,
	output logic [1:0]            status,
	output logic [DIST_W-1:0]     distance_x16,
	output logic [LVL_W-1:0]      level_permille
);

	cfg_t   cfg_q;
	logic   push, pop, q_full, q_empty;
	entry_t push_entry, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_ticks    <= TRIG_W'(10);
			cfg_q.timeout_ticks    <= TMO_W'(30000);
			cfg_q.min_distance_x16 <= DREG_W'(32);
			cfg_q.max_distance_x16 <= DREG_W'(6400);
			cfg_q.tank_height_x16  <= DREG_W'(1600);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_TRIGGER:  cfg_q.trigger_ticks    <= cfg_data[TRIG_W-1:0];
				REG_TIMEOUT:  cfg_q.timeout_ticks    <= cfg_data[TMO_W-1:0];
				REG_MIN_DIST: cfg_q.min_distance_x16 <= cfg_data[DREG_W-1:0];
				REG_MAX_DIST: cfg_q.max_distance_x16 <= cfg_data[DREG_W-1:0];
				REG_TANK:     cfg_q.tank_height_x16  <= cfg_data[DREG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	uer_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start_req  (start_req),
		.echo_level (echo_level),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	uer_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (q_head),
		.full       (q_full),
		.empty      (q_empty)
	);

	uer_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.tank           (cfg_q.tank_height_x16),
		.q_empty        (q_empty),
		.q_head         (q_head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.trigger_out    (trigger_out),
		.done_res       (done_res),
		.status         (status),
		.distance_x16   (distance_x16),
		.level_permille (level_permille)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level_permille <= LVL_W'(1000))
		else $error("level above full scale");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |-> (distance_x16 == '0 && level_permille == '0))
		else $error("nonzero values with error status");

	a_trig_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(trigger_out && done_res))
		else $error("trigger and done on the same beat");

endmodule

[rtl/uer_front.sv]
`timescale 1ns / 1ps
module uer_front
	import uer_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   start_req,
	input  logic   echo_level,
	input  logic   in_valid,
	output logic   in_stall,
	input  logic   q_full,
	output logic   push,
	output entry_t push_entry
);

	phase_t               phase_q, phase_d;
	logic [COUNT_W-1:0]   tick_count_q, count_d, cnt_inc;
	logic [DIST_W-1:0]    last_dist_q;
	status_t              last_status_q;

	logic                 accept;
	logic                 expired, trig_end, trig_short;
	logic [PROD_W-1:0]    prod;
	logic [SDIST_W-1:0]   sdist;
	logic [SAT_W-1:0]     sdist_ext;
	logic [DIST_W-1:0]    dist_sat;
	logic                 in_range;
	logic                 trig, fin;
	status_t              fin_status;
	logic [DIST_W-1:0]    fin_dist;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept;

	assign cnt_inc    = tick_count_q + COUNT_W'(1);
	assign expired    = (TCMP_W'(tick_count_q) >= TCMP_W'(cfg.timeout_ticks)) ||
		(tick_count_q == COUNT_MAX);
	assign trig_end   = (cnt_inc >= COUNT_W'(cfg.trigger_ticks)) || (cnt_inc == '0);
	assign trig_short = cfg.trigger_ticks <= TRIG_W'(1);

	assign prod      = PROD_W'(tick_count_q) * PROD_W'(SPEED_Q12);
	assign sdist     = prod[PROD_W-1:SPEED_SHIFT];
	assign sdist_ext = SAT_W'(sdist);
	assign dist_sat  = (sdist_ext > SAT_W'(DIST_MAX)) ? DIST_MAX : sdist_ext[DIST_W-1:0];
	assign in_range  = !((RCMP_W'(dist_sat) < RCMP_W'(cfg.min_distance_x16)) ||
		(RCMP_W'(dist_sat) > RCMP_W'(cfg.max_distance_x16)));

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req)
					phase_d = trig_short ? PH_RISE : PH_TRIG;
			end
			PH_TRIG: begin
				if (trig_end)
					phase_d = PH_RISE;
			end
			PH_RISE: begin
				if (echo_level)
					phase_d = PH_HIGH;
				else if (expired)
					phase_d = PH_IDLE;
			end
			PH_HIGH: begin
				if (!echo_level || expired)
					phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		count_d    = tick_count_q;
		trig       = 1'b0;
		fin        = 1'b0;
		fin_status = ST_OK;
		fin_dist   = '0;
		unique case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					trig    = 1'b1;
					count_d = trig_short ? COUNT_W'(0) : COUNT_W'(1);
				end
			end
			PH_TRIG: begin
				trig    = 1'b1;
				count_d = trig_end ? COUNT_W'(0) : cnt_inc;
			end
			PH_RISE: begin
				if (echo_level) begin
					count_d = COUNT_W'(1);
				end else if (expired) begin
					fin        = 1'b1;
					fin_status = ST_RISE_TMO;
				end else begin
					count_d = cnt_inc;
				end
			end
			PH_HIGH: begin
				if (echo_level) begin
					if (expired) begin
						fin        = 1'b1;
						fin_status = ST_HIGH_TMO;
					end else begin
						count_d = cnt_inc;
					end
				end else begin
					fin        = 1'b1;
					fin_status = in_range ? ST_OK : ST_RANGE;
					fin_dist   = in_range ? dist_sat : '0;
				end
			end
			default: count_d = '0;
		endcase
		if (fin)
			count_d = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			tick_count_q  <= '0;
			last_dist_q   <= '0;
			last_status_q <= ST_OK;
		end else if (accept) begin
			phase_q      <= phase_d;
			tick_count_q <= count_d;
			if (fin) begin
				last_dist_q   <= fin_dist;
				last_status_q <= fin_status;
			end
		end
	end

	always_comb begin
		push_entry.trig     = trig;
		push_entry.done     = fin;
		push_entry.status   = fin ? fin_status : last_status_q;
		push_entry.dist_x16 = fin ? fin_dist : last_dist_q;
	end

endmodule

[rtl/uer_fifo.sv]
`timescale 1ns / 1ps
module uer_fifo
	import uer_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	input  logic   pop,
	output entry_t head,
	output logic   full,
	output logic   empty
);

	entry_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0]  count_q;
	logic               do_push, do_pop;

	assign full    = count_q == FCNT_W'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + FCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - FCNT_W'(1);
		end
	end

endmodule

[rtl/uer_back.sv]
`timescale 1ns / 1ps
module uer_back
	import uer_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [DREG_W-1:0] tank,
	input  logic              q_empty,
	input  entry_t            q_head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              trigger_out,
	output logic              done_res,
	output logic [1:0]        status,
	output logic [DIST_W-1:0] distance_x16,
	output logic [LVL_W-1:0]  level_permille
);

	back_state_t        state_q, state_d;
	entry_t             entry_q;
	logic [NUM_W-1:0]   rem_q;
	logic [LVL_W-1:0]   quo_q;
	logic [STEP_W-1:0]  idx_q;
	logic               zero_q;
	logic               out_valid_q;
	logic               load;

	logic [RCMP_W-1:0]  diff;
	logic [DREG_W-1:0]  water;
	logic [NUM_W-1:0]   divisor_sh;
	logic               ge;

	// water = clamp(tank - dist, 0, tank)
	assign diff  = RCMP_W'(tank) - RCMP_W'(entry_q.dist_x16);
	assign water = (RCMP_W'(entry_q.dist_x16) >= RCMP_W'(tank)) ? '0 : diff[DREG_W-1:0];

	assign divisor_sh = NUM_W'(tank) << idx_q;
	assign ge         = rem_q >= divisor_sh;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!q_empty) state_d = BK_PREP;
			BK_PREP: state_d = BK_DIV;
			BK_DIV:  if (idx_q == '0) state_d = BK_DONE;
			BK_DONE: if (!out_valid_q || !out_stall) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop  = 1'b0;
		load = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !q_empty;
			BK_DONE: load = !out_valid_q || !out_stall;
			default: begin
				pop  = 1'b0;
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (pop)
			entry_q <= q_head;
		unique case (state_q)
			BK_PREP: begin
				rem_q  <= NUM_W'(water) * NUM_W'(LVL_SCALE);
				quo_q  <= '0;
				idx_q  <= STEP_W'(LVL_W - 1);
				zero_q <= (entry_q.status != ST_OK) || (tank == '0);
			end
			BK_DIV: begin
				if (ge)
					rem_q <= rem_q - divisor_sh;
				quo_q <= {quo_q[LVL_W-2:0], ge};
				idx_q <= idx_q - STEP_W'(1);
			end
			default: begin
			end
		endcase
		if (load) begin
			trigger_out    <= entry_q.trig;
			done_res       <= entry_q.done;
			status         <= entry_q.status;
			distance_x16   <= entry_q.dist_x16;
			level_permille <= zero_q ? '0 : quo_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
